// ===== design/transparent_run_sprite_decoder_defines.svh =====
// Assertion macros for the sprite decoder port-level checker.
`ifndef TRANSPARENT_RUN_SPRITE_DECODER_DEFINES_SVH
`define TRANSPARENT_RUN_SPRITE_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TRSD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("trsd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TRSD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("trsd assertion failed");

`endif

// ===== design/trsd_pkg.sv =====
// Types and constants shared by the sprite decoder modules.
`default_nettype none
package trsd_pkg;

  localparam int COORD_BITS_DEFAULT  = 12;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 14;
  localparam int DIM_W       = 13;
  localparam int ORIGIN_W    = 14;
  localparam int OUT_COORD_W = 12;
  localparam int ADDR_W      = 24;
  localparam int BYTE_W      = 8;

  localparam logic [DIM_W-1:0] DIM_MAX       = 13'd4096;
  localparam logic [DIM_W-1:0] DIM_RESET     = 13'd32;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BUFFER_WIDTH  = 3'd0,
    REG_BUFFER_HEIGHT = 3'd1,
    REG_ORIGIN_X      = 3'd2,
    REG_ORIGIN_Y      = 3'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PH_SKIP  = 2'd0,
    PH_COUNT = 2'd1,
    PH_PIXEL = 2'd2
  } phase_e;

  typedef struct packed {
    logic        [DIM_W-1:0]    buffer_width;
    logic        [DIM_W-1:0]    buffer_height;
    logic signed [ORIGIN_W-1:0] origin_x;
    logic signed [ORIGIN_W-1:0] origin_y;
  } cfg_t;

endpackage
`default_nettype wire

// ===== design/trsd_front.sv =====
// Byte parser: tracks skip/count/pixel phase and the column and row counters.
`default_nettype none
module trsd_front #(
  parameter int COORD_BITS = trsd_pkg::COORD_BITS_DEFAULT
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          byte_valid_i,
  output logic                               byte_ready_o,
  input  wire logic [trsd_pkg::BYTE_W-1:0]   data_byte_i,
  input  wire logic                          end_of_tile_i,
  input  wire logic                          queue_full_i,
  output logic                               push_o,
  output logic [2*COORD_BITS+trsd_pkg::BYTE_W-1:0] push_data_o
);
  import trsd_pkg::*;

  localparam int CW   = COORD_BITS;
  localparam int AddW = ((CW > BYTE_W) ? CW : BYTE_W) + 1;
  localparam logic [CW-1:0] CoordMax = {CW{1'b1}};

  phase_e              phase_q, phase_d;
  logic [BYTE_W-1:0]   skip_q, skip_d;
  logic [BYTE_W-1:0]   run_q, run_d;
  logic [CW-1:0]       col_q, col_d;
  logic [CW-1:0]       row_q, row_d;
  logic                accept;

  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a,
                                            input logic [BYTE_W-1:0] b);
    logic [AddW-1:0] s;
    s = AddW'(a) + AddW'(b);
    return (s > AddW'(CoordMax)) ? CoordMax : s[CW-1:0];
  endfunction

  assign accept = byte_valid_i && byte_ready_o;

  // next state and counters
  always_comb begin
    phase_d = phase_q;
    skip_d  = skip_q;
    run_d   = run_q;
    col_d   = col_q;
    row_d   = row_q;
    if (accept) begin
      case (phase_q)
        PH_COUNT: begin
          if (skip_q == '0 && data_byte_i == '0) begin
            col_d   = '0;
            row_d   = sat_add(row_q, BYTE_W'(1));
            phase_d = PH_SKIP;
          end else begin
            col_d   = sat_add(col_q, skip_q);
            run_d   = data_byte_i;
            phase_d = (data_byte_i != '0) ? PH_PIXEL : PH_SKIP;
          end
        end
        PH_PIXEL: begin
          col_d = sat_add(col_q, BYTE_W'(1));
          run_d = run_q - BYTE_W'(1);
          if (run_q == BYTE_W'(1)) begin
            phase_d = PH_SKIP;
          end
        end
        default: begin
          skip_d  = data_byte_i;
          phase_d = PH_COUNT;
        end
      endcase
      if (end_of_tile_i) begin
        phase_d = PH_SKIP;
        skip_d  = '0;
        run_d   = '0;
        col_d   = '0;
        row_d   = '0;
      end
    end
  end

  // outputs: stall only when a pixel byte meets a full queue
  always_comb begin
    byte_ready_o = (phase_q != PH_PIXEL) || !queue_full_i;
    push_o       = byte_valid_i && !queue_full_i && (phase_q == PH_PIXEL);
    push_data_o  = {col_q, row_q, data_byte_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SKIP;
      skip_q  <= '0;
      run_q   <= '0;
      col_q   <= '0;
      row_q   <= '0;
    end else begin
      phase_q <= phase_d;
      skip_q  <= skip_d;
      run_q   <= run_d;
      col_q   <= col_d;
      row_q   <= row_d;
    end
  end

endmodule
`default_nettype wire

// ===== design/trsd_fifo.sv =====
// Short queue of pixel candidates between parser and address stage.
`default_nettype none
module trsd_fifo #(
  parameter int WIDTH = 32,
  parameter int DEPTH = trsd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output logic [WIDTH-1:0]      head_o
);
  import trsd_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule
`default_nettype wire

// ===== design/trsd_back.sv =====
// Offset, clip and address pipeline feeding the output register.
`default_nettype none
module trsd_back #(
  parameter int COORD_BITS = trsd_pkg::COORD_BITS_DEFAULT
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire trsd_pkg::cfg_t                          cfg_i,
  input  wire logic                                    queue_empty_i,
  input  wire logic [2*COORD_BITS+trsd_pkg::BYTE_W-1:0] queue_head_i,
  output logic                                         pop_o,
  output logic                                         pixel_valid_o,
  input  wire logic                                    pixel_ready_i,
  output logic [trsd_pkg::OUT_COORD_W-1:0]             pixel_x_o,
  output logic [trsd_pkg::OUT_COORD_W-1:0]             pixel_y_o,
  output logic [trsd_pkg::ADDR_W-1:0]                  pixel_address_o,
  output logic [trsd_pkg::BYTE_W-1:0]                  pixel_value_o
);
  import trsd_pkg::*;

  localparam int CW   = COORD_BITS;
  localparam int SumW = ((CW > DIM_W) ? CW : DIM_W) + 2;
  localparam int MulW = OUT_COORD_W + DIM_W;

  logic [CW-1:0]            head_col, head_row;
  logic [BYTE_W-1:0]        head_val;
  logic [DIM_W-1:0]         w_clamp, h_clamp;
  logic signed [SumW-1:0]   px, py;
  logic                     in_buffer;

  logic                     a_valid_q;
  logic [OUT_COORD_W-1:0]   a_x_q, a_y_q;
  logic [BYTE_W-1:0]        a_val_q;
  logic                     out_free, a_free;
  logic [MulW-1:0]          product;

  assign {head_col, head_row, head_val} = queue_head_i;

  assign w_clamp = (cfg_i.buffer_width  > DIM_MAX) ? DIM_MAX : cfg_i.buffer_width;
  assign h_clamp = (cfg_i.buffer_height > DIM_MAX) ? DIM_MAX : cfg_i.buffer_height;

  assign px = SumW'(cfg_i.origin_x) + $signed({{(SumW-CW){1'b0}}, head_col});
  assign py = SumW'(cfg_i.origin_y) + $signed({{(SumW-CW){1'b0}}, head_row});

  assign in_buffer = !px[SumW-1] && !py[SumW-1]
                  && (px < $signed({{(SumW-DIM_W){1'b0}}, w_clamp}))
                  && (py < $signed({{(SumW-DIM_W){1'b0}}, h_clamp}));

  assign out_free = !pixel_valid_o || pixel_ready_i;
  assign a_free   = !a_valid_q || out_free;
  assign pop_o    = !queue_empty_i && a_free;
  assign product  = MulW'(a_y_q) * MulW'(w_clamp);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q     <= 1'b0;
      pixel_valid_o <= 1'b0;
    end else begin
      if (a_free) begin
        a_valid_q <= pop_o && in_buffer;
      end
      if (out_free) begin
        pixel_valid_o <= a_valid_q;
      end
    end
  end

  // payload: drop clipped candidates, keep only the low coordinate bits
  always_ff @(posedge clk_i) begin
    if (a_free) begin
      a_x_q   <= px[OUT_COORD_W-1:0];
      a_y_q   <= py[OUT_COORD_W-1:0];
      a_val_q <= head_val;
    end
    if (out_free && a_valid_q) begin
      pixel_x_o       <= a_x_q;
      pixel_y_o       <= a_y_q;
      pixel_address_o <= product[ADDR_W-1:0] + ADDR_W'(a_x_q);
      pixel_value_o   <= a_val_q;
    end
  end

endmodule
`default_nettype wire

// ===== design/transparent_run_sprite_decoder.sv =====
// A pixel byte is written into the queue, then registered in the address stage, then in the output register.
// Throughput: one byte per cycle; only pixel bytes stall, and only on a full queue.
// The rate is set by the queue push at the parser and the two-stage address pipe.
// Reset (rst_ni low, asynchronous): parser, queue and output valid clear;
// config returns to width 32, height 32, origin 0,0.
`default_nettype none
module transparent_run_sprite_decoder #(
  parameter int COORD_BITS  = trsd_pkg::COORD_BITS_DEFAULT,
  parameter int QUEUE_DEPTH = trsd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [trsd_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  wire logic [trsd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic                              byte_valid_i,
  output logic                                   byte_ready_o,
  input  wire logic [trsd_pkg::BYTE_W-1:0]       data_byte_i,
  input  wire logic                              end_of_tile_i,
  output logic                                   pixel_valid_o,
  input  wire logic                              pixel_ready_i,
  output logic [trsd_pkg::OUT_COORD_W-1:0]       pixel_x_o,
  output logic [trsd_pkg::OUT_COORD_W-1:0]       pixel_y_o,
  output logic [trsd_pkg::ADDR_W-1:0]            pixel_address_o,
  output logic [trsd_pkg::BYTE_W-1:0]            pixel_value_o
);
  import trsd_pkg::*;

  // A queued word is {column, row, palette index}.
  localparam int QW = 2 * COORD_BITS + BYTE_W;

  cfg_t          cfg_q;
  logic          push, pop, q_full, q_empty;
  logic [QW-1:0] push_data, q_head;

  // Hold config; writes to indexes past the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.buffer_width  <= DIM_RESET;
      cfg_q.buffer_height <= DIM_RESET;
      cfg_q.origin_x      <= '0;
      cfg_q.origin_y      <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_BUFFER_WIDTH:  cfg_q.buffer_width  <= cfg_data_i[DIM_W-1:0];
        REG_BUFFER_HEIGHT: cfg_q.buffer_height <= cfg_data_i[DIM_W-1:0];
        REG_ORIGIN_X:      cfg_q.origin_x      <= $signed(cfg_data_i[ORIGIN_W-1:0]);
        REG_ORIGIN_Y:      cfg_q.origin_y      <= $signed(cfg_data_i[ORIGIN_W-1:0]);
        default: begin
        end
      endcase
    end
  end

  // Front: parse every byte; push a word per pixel byte, clipped or not.
  trsd_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .byte_valid_i  (byte_valid_i),
    .byte_ready_o  (byte_ready_o),
    .data_byte_i   (data_byte_i),
    .end_of_tile_i (end_of_tile_i),
    .queue_full_i  (q_full),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  // Queue: lets the parser run on while the output side stalls.
  trsd_fifo #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .head_o      (q_head)
  );

  // Back: offset, clip, then multiply for the linear address.
  trsd_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .queue_empty_i   (q_empty),
    .queue_head_i    (q_head),
    .pop_o           (pop),
    .pixel_valid_o   (pixel_valid_o),
    .pixel_ready_i   (pixel_ready_i),
    .pixel_x_o       (pixel_x_o),
    .pixel_y_o       (pixel_y_o),
    .pixel_address_o (pixel_address_o),
    .pixel_value_o   (pixel_value_o)
  );

endmodule
`default_nettype wire

// ===== design/trsd_checker.sv =====
// Port-level checker for the sprite decoder, bound to the top level.
`default_nettype none
`include "transparent_run_sprite_decoder_defines.svh"
module trsd_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              cfg_we_i,
  input wire logic [trsd_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input wire logic [trsd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input wire logic                              pixel_valid_o,
  input wire logic                              pixel_ready_i,
  input wire logic [trsd_pkg::OUT_COORD_W-1:0]  pixel_x_o,
  input wire logic [trsd_pkg::OUT_COORD_W-1:0]  pixel_y_o,
  input wire logic [trsd_pkg::ADDR_W-1:0]       pixel_address_o,
  input wire logic [trsd_pkg::BYTE_W-1:0]       pixel_value_o
);
  import trsd_pkg::*;

  logic [DIM_W-1:0]  width_q, height_q;
  logic [DIM_W-1:0]  w_clamp, h_clamp;
  logic [ADDR_W+1:0] expect_addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_RESET;
      height_q <= DIM_RESET;
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_BUFFER_WIDTH) begin
        width_q <= cfg_data_i[DIM_W-1:0];
      end
      if (cfg_index_i == REG_BUFFER_HEIGHT) begin
        height_q <= cfg_data_i[DIM_W-1:0];
      end
    end
  end

  assign w_clamp     = (width_q  > DIM_MAX) ? DIM_MAX : width_q;
  assign h_clamp     = (height_q > DIM_MAX) ? DIM_MAX : height_q;
  assign expect_addr = (ADDR_W+2)'(pixel_y_o) * (ADDR_W+2)'(w_clamp)
                     + (ADDR_W+2)'(pixel_x_o);

  `TRSD_ASSERT_NXT(a_out_hold, clk_i, rst_ni, pixel_valid_o && !pixel_ready_i, pixel_valid_o && $stable(pixel_address_o) && $stable(pixel_value_o))
  `TRSD_ASSERT_IMP(a_out_in_buffer, clk_i, rst_ni, pixel_valid_o, (13'(pixel_x_o) < w_clamp) && (13'(pixel_y_o) < h_clamp))
  `TRSD_ASSERT_IMP(a_out_address, clk_i, rst_ni, pixel_valid_o, pixel_address_o == expect_addr[ADDR_W-1:0])

endmodule

bind transparent_run_sprite_decoder trsd_checker u_trsd_checker (.*);
`default_nettype wire

// ===== bench/sprite_pixel_checker.sv =====
// Pixel predictor and scoreboard for the transparent run sprite decoder.
module sprite_pixel_checker
  import trsd_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   byte_valid_i,
  input  logic                   byte_ready_i,
  input  logic [BYTE_W-1:0]      data_byte_i,
  input  logic                   end_of_tile_i,
  input  logic                   pixel_valid_i,
  input  logic                   pixel_ready_i,
  input  logic [OUT_COORD_W-1:0] pixel_x_i,
  input  logic [OUT_COORD_W-1:0] pixel_y_i,
  input  logic [ADDR_W-1:0]      pixel_address_i,
  input  logic [BYTE_W-1:0]      pixel_value_i,
  output int                     fail_count_o,
  output int                     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_MAX    = (1 << COORD_BITS) - 1;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [OUT_COORD_W-1:0] x;
    logic [OUT_COORD_W-1:0] y;
    logic [ADDR_W-1:0]      addr;
    logic [BYTE_W-1:0]      value;
  } pixel_t;

  logic        [DIM_W-1:0]      buffer_width;
  logic        [DIM_W-1:0]      buffer_height;
  logic signed [ORIGIN_W-1:0]   origin_x;
  logic signed [ORIGIN_W-1:0]   origin_y;
  phase_e                       parse_phase;
  logic        [BYTE_W-1:0]     held_skip;
  logic        [BYTE_W-1:0]     run_left;
  logic        [COORD_BITS-1:0] column_count;
  logic        [COORD_BITS-1:0] row_count;
  pixel_t                       expected_pixels[$];

  function automatic logic [COORD_BITS-1:0] sat_sum(input int a, input int b);
    int s;
    s = a + b;
    return COORD_BITS'((s > COORD_MAX) ? COORD_MAX : s);
  endfunction

  task automatic clear_parser();
    parse_phase  = PH_SKIP;
    held_skip    = '0;
    run_left     = '0;
    column_count = '0;
    row_count    = '0;
  endtask

  // Advance the parser by one word and queue the pixel it writes, if any.
  task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic last);
    int     px;
    int     py;
    int     w;
    int     h;
    pixel_t pix;
    case (parse_phase)
      PH_COUNT: begin
        if (held_skip == 0 && b == 0) begin
          column_count = '0;
          row_count    = sat_sum(row_count, 1);
          parse_phase  = PH_SKIP;
        end else begin
          column_count = sat_sum(column_count, held_skip);
          run_left     = b;
          parse_phase  = (b != 0) ? PH_PIXEL : PH_SKIP;
        end
      end
      PH_PIXEL: begin
        px = origin_x + int'(column_count);
        py = origin_y + int'(row_count);
        w  = buffer_width;
        h  = buffer_height;
        if (w > int'(DIM_MAX)) w = DIM_MAX;
        if (h > int'(DIM_MAX)) h = DIM_MAX;
        if (px >= 0 && py >= 0 && px < w && py < h) begin
          pix.x     = px[OUT_COORD_W-1:0];
          pix.y     = py[OUT_COORD_W-1:0];
          pix.addr  = ADDR_W'(py * w + px);
          pix.value = b;
          expected_pixels.push_back(pix);
        end
        column_count = sat_sum(column_count, 1);
        run_left     = run_left - 1'b1;
        if (run_left == 0) parse_phase = PH_SKIP;
      end
      default: begin
        held_skip   = b;
        parse_phase = PH_COUNT;
      end
    endcase
    if (last) clear_parser();
  endtask

  task automatic note_failure(input string msg);
    fail_count_o++;
    if (fail_count_o <= REPORT_LIMIT) $display("%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t got;
    pixel_t want;
    if (!rst_ni) begin
      buffer_width  = DIM_RESET;
      buffer_height = DIM_RESET;
      origin_x      = '0;
      origin_y      = '0;
      clear_parser();
      expected_pixels.delete();
      fail_count_o  = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_BUFFER_WIDTH:  buffer_width  = cfg_data_i[DIM_W-1:0];
          REG_BUFFER_HEIGHT: buffer_height = cfg_data_i[DIM_W-1:0];
          REG_ORIGIN_X:      origin_x      = cfg_data_i[ORIGIN_W-1:0];
          REG_ORIGIN_Y:      origin_y      = cfg_data_i[ORIGIN_W-1:0];
          default: ;
        endcase
      end
      if (byte_valid_i && byte_ready_i) decode_byte(data_byte_i, end_of_tile_i);
      if (pixel_valid_i && pixel_ready_i) begin
        got.x     = pixel_x_i;
        got.y     = pixel_y_i;
        got.addr  = pixel_address_i;
        got.value = pixel_value_i;
        if (expected_pixels.size() == 0) begin
          note_failure($sformatf("unexpected pixel x=%0d y=%0d addr=%0d value=%0d",
                                 got.x, got.y, got.addr, got.value));
        end else begin
          want = expected_pixels.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.addr !== want.addr ||
              got.value !== want.value) begin
            note_failure($sformatf(
              "pixel mismatch: expected x=%0d y=%0d addr=%0d value=%0d, got x=%0d y=%0d addr=%0d value=%0d",
              want.x, want.y, want.addr, want.value, got.x, got.y, got.addr, got.value));
          end
        end
      end
    end
    pending_o = expected_pixels.size();
  end

endmodule

// ===== bench/transparent_run_sprite_decoder_tb.sv =====
// Top of the sprite decoder bench: clock, reset, word stimulus, register setup and verdict.
module transparent_run_sprite_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import trsd_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int HOLD_CYCLES   = 200;      // long receiver hold-off to fill the pixel queue
  localparam int SETTLE_CYCLES = 8;        // covers the queue, the address stage and the output register with margin
  localparam int TIMEOUT_NS    = 5_000_000;

  // Directed words: bit 8 is end_of_tile, bits 7:0 the data byte.
  localparam logic [8:0] DIRECTED_WORDS [25] = '{
    9'h000, 9'h003, 9'h000, 9'h0FF, 9'h0A5,  // run of three at column 0, value extremes
    9'h005, 9'h000,                          // nonzero skip, zero count: skip only
    9'h002, 9'h001, 9'h05A,                  // single pixel after the skipped columns
    9'h000, 9'h000,                          // row end
    9'h001, 9'h003, 9'h011, 9'h122,          // tile ends inside a run, third pixel dropped
    9'h0FF, 9'h001, 9'h13C,                  // widest skip, pixel clipped, tile ends on it
    9'h107,                                  // tile ends on a skip word
    9'h000, 9'h101,                          // tile ends on a count word
    9'h003, 9'h001, 9'h181                   // fresh parser after the early ends
  };

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   cfg_we      = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index   = '0;
  logic [CFG_DATA_W-1:0]  cfg_data    = '0;
  logic                   byte_valid  = 1'b0;
  logic                   byte_ready;
  logic [BYTE_W-1:0]      data_byte   = '0;
  logic                   end_of_tile = 1'b0;
  logic                   pixel_valid;
  logic                   pixel_ready = 1'b0;
  logic [OUT_COORD_W-1:0] pixel_x;
  logic [OUT_COORD_W-1:0] pixel_y;
  logic [ADDR_W-1:0]      pixel_address;
  logic [BYTE_W-1:0]      pixel_value;

  int send_idle_pct = 21;
  int recv_idle_pct = 79;
  int hold_ask      = 0;   // bumped by the stimulus to request a hold-off
  int hold_seen     = 0;   // owned by the receiver process
  int hold_left     = 0;
  int sent_words    = 0;
  int fail_count;
  int pending;

  always #CLK_HALF clk = ~clk;

  transparent_run_sprite_decoder u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .byte_valid_i    (byte_valid),
    .byte_ready_o    (byte_ready),
    .data_byte_i     (data_byte),
    .end_of_tile_i   (end_of_tile),
    .pixel_valid_o   (pixel_valid),
    .pixel_ready_i   (pixel_ready),
    .pixel_x_o       (pixel_x),
    .pixel_y_o       (pixel_y),
    .pixel_address_o (pixel_address),
    .pixel_value_o   (pixel_value)
  );

  sprite_pixel_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .byte_valid_i    (byte_valid),
    .byte_ready_i    (byte_ready),
    .data_byte_i     (data_byte),
    .end_of_tile_i   (end_of_tile),
    .pixel_valid_i   (pixel_valid),
    .pixel_ready_i   (pixel_ready),
    .pixel_x_i       (pixel_x),
    .pixel_y_i       (pixel_y),
    .pixel_address_i (pixel_address),
    .pixel_value_i   (pixel_value),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  // Receiver: random back-pressure, or a solid hold-off when the stimulus asks.
  // The hold is counted here so the sender keeps pushing words meanwhile.
  always @(posedge clk) begin
    if (hold_seen != hold_ask) begin
      hold_seen = hold_ask;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      pixel_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      pixel_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offer one word, with random idle cycles ahead of it, and hold it until taken.
  // Valid stays high on return so back-to-back words need no extra assignment.
  task automatic send_byte(input logic [BYTE_W-1:0] value, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid  <= 1'b1;
    data_byte   <= value;
    end_of_tile <= last;
    @(posedge clk);
    while (!byte_ready) @(posedge clk);
    sent_words++;
  endtask

  // Drop valid and wait until every predicted pixel has come out, then let the
  // pipe settle, since a clipped pixel word may still be in flight.
  task automatic wait_drained();
    byte_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all four registers on consecutive edges; the block must be idle.
  task automatic apply_setting(input logic [CFG_DATA_W-1:0] width,
                               input logic [CFG_DATA_W-1:0] height,
                               input logic [CFG_DATA_W-1:0] org_x,
                               input logic [CFG_DATA_W-1:0] org_y);
    cfg_we    <= 1'b1;
    cfg_index <= REG_BUFFER_WIDTH;
    cfg_data  <= width;
    @(posedge clk);
    cfg_index <= REG_BUFFER_HEIGHT;
    cfg_data  <= height;
    @(posedge clk);
    cfg_index <= REG_ORIGIN_X;
    cfg_data  <= org_x;
    @(posedge clk);
    cfg_index <= REG_ORIGIN_Y;
    cfg_data  <= org_y;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Well-formed tile: rows of skip/count pairs with their runs, rows split by
  // a zero pair. Now and then the tile is cut short with end_of_tile anywhere.
  task automatic send_tile();
    logic [BYTE_W-1:0] tile_words[$];
    int rows;
    int pairs;
    int skip;
    int count;
    int cut;
    rows = $urandom_range(1, 5);
    for (int r = 0; r < rows; r++) begin
      pairs = $urandom_range(0, 3);
      for (int p = 0; p < pairs; p++) begin
        skip  = ($urandom_range(15) == 0) ? $urandom_range(255) : $urandom_range(6);
        count = ($urandom_range(31) == 0) ? $urandom_range(255) : $urandom_range(8);
        if (skip == 0 && count == 0) count = 1;  // keep the row going
        tile_words.push_back(BYTE_W'(skip));
        tile_words.push_back(BYTE_W'(count));
        repeat (count) tile_words.push_back(BYTE_W'($urandom_range(255)));
      end
      if (r != rows - 1 || tile_words.size() == 0) begin
        tile_words.push_back(8'd0);
        tile_words.push_back(8'd0);
      end
    end
    cut = tile_words.size();
    if ($urandom_range(7) == 0) cut = $urandom_range(1, tile_words.size());
    for (int i = 0; i < cut; i++) send_byte(tile_words[i], i == cut - 1);
  endtask

  // Raw noise, always closed with end_of_tile so the next tile starts clean.
  task automatic send_noise();
    int len;
    len = $urandom_range(3, 12);
    for (int i = 0; i < len; i++)
      send_byte(BYTE_W'($urandom_range(255)), (i == len - 1) || ($urandom_range(7) == 0));
  endtask

  task automatic run_random(input int n);
    int stop_at;
    stop_at = sent_words + n;
    while (sent_words < stop_at) begin
      if ($urandom_range(4) == 0) send_noise();
      else send_tile();
    end
  endtask

  // Step a few rows down, drive the column counter into saturation with wide
  // skips, then a short run that must land at the saturated column.
  task automatic saturate_counters();
    repeat (5) begin
      send_byte(8'd0, 1'b0);
      send_byte(8'd0, 1'b0);
    end
    repeat (20) begin
      send_byte(8'd255, 1'b0);
      send_byte(8'd0, 1'b0);
    end
    send_byte(8'd0, 1'b0);
    send_byte(8'd3, 1'b0);
    send_byte(BYTE_W'($urandom_range(255)), 1'b0);
    send_byte(BYTE_W'($urandom_range(255)), 1'b0);
    send_byte(BYTE_W'($urandom_range(255)), 1'b1);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words under the reset geometry (32x32, origin 0,0).
    foreach (DIRECTED_WORDS[i]) send_byte(DIRECTED_WORDS[i][7:0], DIRECTED_WORDS[i][8]);

    // Hold the receiver off while a long visible run streams in: the queue
    // fills and the block must stall its input. Then pause until all is out.
    hold_ask <= hold_ask + 1;
    send_byte(8'd0, 1'b0);
    send_byte(8'd30, 1'b0);
    for (int i = 0; i < 30; i++) send_byte(BYTE_W'($urandom_range(255)), i == 29);
    wait_drained();

    // Sender mostly busy, receiver mostly stalled.
    apply_setting(14'd64, 14'd16, -14'sd5, -14'sd3);
    run_random(300);
    wait_drained();
    apply_setting(14'd1, 14'd1, 14'd0, 14'd0);
    run_random(150);
    wait_drained();

    // Sender mostly idle, receiver mostly ready.
    send_idle_pct <= 79;
    recv_idle_pct <= 21;
    // Oversized dimensions clamp to 4096; origin near the far corner reaches
    // the top of the address range.
    apply_setting(14'd8191, 14'd8191, 14'd4060, 14'd4090);
    run_random(300);
    wait_drained();
    apply_setting(14'd0, 14'd4096, 14'd0, 14'd0);
    run_random(50);
    wait_drained();
    apply_setting(14'd20, 14'd0, 14'd0, 14'd0);
    run_random(50);
    wait_drained();
    apply_setting(14'd20, 14'd4096, -14'sd8192, 14'sd8191);
    run_random(50);
    wait_drained();

    // No idling on either side.
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    apply_setting(14'd13, 14'd9, 14'd3, 14'd2);
    run_random(300);
    wait_drained();
    apply_setting(14'd8, 14'd16, -14'sd4090, 14'd0);
    saturate_counters();
    wait_drained();
    apply_setting(14'd32, 14'd32, 14'd0, 14'd0);
    run_random(150);
    wait_drained();

    @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[transparent_run_sprite_decoder] OK");
    end else begin
      $display("[transparent_run_sprite_decoder] ERROR");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    #(TIMEOUT_NS);
    $display("[transparent_run_sprite_decoder] ERROR");
    $finish;
  end

endmodule

// ===== transparent_run_sprite_decoder.f =====
+incdir+design
design/trsd_pkg.sv
design/trsd_front.sv
design/trsd_fifo.sv
design/trsd_back.sv
design/transparent_run_sprite_decoder.sv
design/trsd_checker.sv
bench/sprite_pixel_checker.sv
bench/transparent_run_sprite_decoder_tb.sv
